// File: hw/rtl/sha224_pkg.sv
`timescale 1ns / 1ps
package sha224_pkg;

	localparam int unsigned NumWords    = 8;
	localparam int unsigned DigestWords = 7;
	localparam int unsigned NumRounds   = 64;
	localparam int unsigned BlockBytes  = 64;
	localparam int unsigned PadStart    = 56;
	localparam logic [7:0]  PadByte     = 8'h80;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic       load;
		logic [5:0] load_idx;
		logic [7:0] load_byte;
		logic       start;
		logic       clear;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
	} dp_sts_t;

	function automatic word_t iv_word(input logic [2:0] idx);
		word_t r;
		r = '0;
		unique case (idx)
			3'd0: r = 32'hC1059ED8;
			3'd1: r = 32'h367CD507;
			3'd2: r = 32'h3070DD17;
			3'd3: r = 32'hF70E5939;
			3'd4: r = 32'hFFC00B31;
			3'd5: r = 32'h68581511;
			3'd6: r = 32'h64F98FA7;
			3'd7: r = 32'hBEFA4FA4;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] idx);
		word_t k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[idx];
	endfunction

	function automatic word_t rotr(input word_t v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

endpackage

// File: hw/rtl/sha224_dp.sv
`timescale 1ns / 1ps
module sha224_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sha224_pkg::dp_cmd_t cmd,
	output sha224_pkg::dp_sts_t sts,
	input  logic [2:0]          rd_idx,
	output sha224_pkg::word_t   rd_word
);

	sha224_pkg::word_t hash_q [8];
	sha224_pkg::word_t w_q [16];
	sha224_pkg::word_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [5:0] rnd_q;
	logic       run_q;
	logic       fold_q;

	sha224_pkg::word_t t1, t2, s0, s1, wnew, w0;

	// rolling 16-word schedule window, w_q[0] is the current round word
	always_comb begin
		w0   = w_q[0];
		s0   = sha224_pkg::rotr(w_q[1], 7) ^ sha224_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = sha224_pkg::rotr(w_q[14], 17) ^ sha224_pkg::rotr(w_q[14], 19)
			^ (w_q[14] >> 10);
		wnew = s1 + w_q[9] + s0 + w_q[0];
		t1   = h_q + (sha224_pkg::rotr(e_q, 6) ^ sha224_pkg::rotr(e_q, 11)
			^ sha224_pkg::rotr(e_q, 25)) + ((e_q & f_q) ^ (~e_q & g_q))
			+ sha224_pkg::round_k(rnd_q) + w0;
		t2   = (sha224_pkg::rotr(a_q, 2) ^ sha224_pkg::rotr(a_q, 13)
			^ sha224_pkg::rotr(a_q, 22)) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fold_q <= 1'b0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha224_pkg::iv_word(3'(i));
		end else begin
			if (cmd.clear) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= sha224_pkg::iv_word(3'(i));
			end
			if (cmd.start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(sha224_pkg::NumRounds - 1)) begin
					run_q  <= 1'b0;
					fold_q <= 1'b1;
				end
			end
			if (fold_q) begin
				fold_q    <= 1'b0;
				hash_q[0] <= hash_q[0] + a_q;
				hash_q[1] <= hash_q[1] + b_q;
				hash_q[2] <= hash_q[2] + c_q;
				hash_q[3] <= hash_q[3] + d_q;
				hash_q[4] <= hash_q[4] + e_q;
				hash_q[5] <= hash_q[5] + f_q;
				hash_q[6] <= hash_q[6] + g_q;
				hash_q[7] <= hash_q[7] + h_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			unique case (cmd.load_idx[1:0])
				2'd0: w_q[cmd.load_idx[5:2]][31:24] <= cmd.load_byte;
				2'd1: w_q[cmd.load_idx[5:2]][23:16] <= cmd.load_byte;
				2'd2: w_q[cmd.load_idx[5:2]][15:8]  <= cmd.load_byte;
				2'd3: w_q[cmd.load_idx[5:2]][7:0]   <= cmd.load_byte;
				default: ;
			endcase
		end
		if (cmd.start) begin
			a_q <= hash_q[0]; b_q <= hash_q[1]; c_q <= hash_q[2]; d_q <= hash_q[3];
			e_q <= hash_q[4]; f_q <= hash_q[5]; g_q <= hash_q[6]; h_q <= hash_q[7];
		end else if (run_q) begin
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wnew;
		end
	end

	assign sts.busy = run_q | fold_q;
	assign rd_word  = hash_q[rd_idx];

endmodule

// File: hw/rtl/sha224_ctrl.sv
`timescale 1ns / 1ps
module sha224_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [7:0]          data_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          out_idx,
	output sha224_pkg::dp_cmd_t cmd,
	input  sha224_pkg::dp_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_WAIT, ST_PAD, ST_LEN, ST_EMIT
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        fin_q;
	logic [2:0]  oidx_q;
	logic        kick_q;

	logic       acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid & in_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign out_idx   = oidx_q;

	always_comb begin
		cmd           = '0;
		cmd.start     = kick_q;
		cmd.load_idx  = fill_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load      = acc;
				cmd.load_byte = mode ? sha224_pkg::PadByte : data_byte;
			end
			ST_PAD: begin
				cmd.load = 1'b1;
			end
			ST_LEN: begin
				cmd.load      = 1'b1;
				cmd.load_byte = 8'(bits_q >> {fill_q[2:0] ^ 3'd7, 3'd0});
			end
			ST_EMIT: cmd.clear = out_ready & (oidx_q == 3'(sha224_pkg::DigestWords - 1));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			fin_q   <= 1'b0;
			oidx_q  <= '0;
			kick_q  <= 1'b0;
		end else begin
			kick_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (acc) begin
					fill_q <= fill_q + 6'd1;
					if (!mode) begin
						bits_q <= bits_q + 64'd8;
						if (fill_q == 6'd63) begin
							kick_q  <= 1'b1;
							state_q <= ST_WAIT;
						end
					end else begin
						fin_q <= 1'b1;
						if (fill_q == 6'd63) begin
							kick_q  <= 1'b1;
							state_q <= ST_WAIT;
						end else if (fill_q == 6'(sha224_pkg::PadStart - 1)) begin
							state_q <= ST_LEN;
						end else begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_WAIT: if (!kick_q && !sts.busy) begin
					state_q <= ST_IDLE;
					if (fin_q) begin
						state_q <= (fill_q == 6'd0 && bits_q == '0 && oidx_q == 3'd7)
							? ST_EMIT : ST_PAD;
						if (oidx_q == 3'd7) begin
							oidx_q  <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						kick_q  <= 1'b1;
						state_q <= ST_WAIT;
					end else if (fill_q == 6'(sha224_pkg::PadStart - 1)) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						kick_q  <= 1'b1;
						oidx_q  <= 3'd7;
						state_q <= ST_WAIT;
					end
				end
				ST_EMIT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'(sha224_pkg::DigestWords - 1)) begin
						oidx_q  <= '0;
						fill_q  <= '0;
						bits_q  <= '0;
						fin_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/sha224_hash_engine_unit.sv
`timescale 1ns / 1ps
// bytes are taken one per cycle while idle; a block's 64th byte starts the compression
// finalize: padding fill plus one or two compressions, then seven digest items
// the compression loop runs one round per cycle
// one item is worked at a time; input is not ready during compression or digest output
// reset: asynchronous, loads the initial hash values with zero length and empty block
module sha224_hash_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word, word_index, zero fill
	output logic        m_tlast   // last_word
);

	sha224_pkg::dp_cmd_t cmd;
	sha224_pkg::dp_sts_t sts;
	logic [2:0]          oidx;
	sha224_pkg::word_t   word;

	sha224_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.mode      (s_tuser),
		.data_byte (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_idx   (oidx),
		.cmd       (cmd),
		.sts       (sts)
	);

	sha224_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.rd_idx  (oidx),
		.rd_word (word)
	);

	assign m_tdata = {5'd0, oidx, word};
	assign m_tlast = (oidx == 3'(sha224_pkg::DigestWords - 1));

endmodule
